/* hdl/pcsw_pkg.sv */
// shared types and constants for the pulse-count single-wire writer
package pcsw_pkg;

    localparam int ACTION_W  = 2;
    localparam int ADDRESS_W = 4;
    localparam int DATA_W    = 8;
    localparam int PULSE_W   = 8;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_OFF  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 1'd1;

    localparam logic [PULSE_W-1:0] PULSE_TICKS_RESET = 8'd1;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RESET  = 16'd560;
    localparam logic [ADDRESS_W-1:0] MAX_ADDRESS     = 4'd5;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_ticks;
        logic [HOLD_W-1:0]  hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [ADDRESS_W-1:0] address;
        logic [DATA_W-1:0]    data;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic rejected;
        logic frame_done;
    } result_t;

endpackage

/* hdl/pcsw_in_if.sv */
// input item channel
interface pcsw_in_if;
    logic                           valid;
    logic                           ready;
    logic [pcsw_pkg::ACTION_W-1:0]  action;
    logic [pcsw_pkg::ADDRESS_W-1:0] address;
    logic [pcsw_pkg::DATA_W-1:0]    data;

    modport source (output valid, output action, output address, output data, input ready);
    modport sink (input valid, input action, input address, input data, output ready);
endinterface

/* hdl/pcsw_out_if.sv */
// result item channel
interface pcsw_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic rejected;
    logic frame_done;

    modport source (output valid, output line_level, output busy_res, output rejected,
                    output frame_done, input ready);
    modport sink (input valid, input line_level, input busy_res, input rejected,
                  input frame_done, output ready);
endinterface

/* hdl/pcsw_cfg_if.sv */
// configuration write channel
interface pcsw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pcsw_pkg::CFG_IDX_W-1:0]  index;
    logic [pcsw_pkg::CFG_DAT_W-1:0]  wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

/* hdl/pcsw_cfg_regs.sv */
// configuration registers
module pcsw_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    pcsw_cfg_if.sink        cfg_ch,
    output pcsw_pkg::cfg_t  cfg
);

    logic [pcsw_pkg::PULSE_W-1:0] pulse_ticks_reg;
    logic [pcsw_pkg::HOLD_W-1:0]  hold_ticks_reg;
    logic                         wr_en;

    assign cfg_ch.ready = 1'b1;
    assign wr_en        = cfg_ch.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg <= pcsw_pkg::PULSE_TICKS_RESET;
            hold_ticks_reg  <= pcsw_pkg::HOLD_TICKS_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_ch.index)
                pcsw_pkg::REG_PULSE_TICKS:
                    pulse_ticks_reg <= cfg_ch.wdata[pcsw_pkg::PULSE_W-1:0];
                pcsw_pkg::REG_HOLD_TICKS:
                    hold_ticks_reg <= cfg_ch.wdata[pcsw_pkg::HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.pulse_ticks = pulse_ticks_reg;
    assign cfg.hold_ticks  = hold_ticks_reg;

endmodule

/* hdl/pcsw_frame_fsm.sv */
// frame sequencer: phase, segment timer and pulse counters
module pcsw_frame_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  pcsw_pkg::item_t    item,
    input  pcsw_pkg::cfg_t     cfg,
    output pcsw_pkg::result_t  result
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_A_LOW  = 3'd1;
    localparam logic [2:0] PH_A_HIGH = 3'd2;
    localparam logic [2:0] PH_A_HOLD = 3'd3;
    localparam logic [2:0] PH_D_LOW  = 3'd4;
    localparam logic [2:0] PH_D_HIGH = 3'd5;
    localparam logic [2:0] PH_D_HOLD = 3'd6;

    logic [2:0]                   phase_reg,  phase_next;
    logic [pcsw_pkg::HOLD_W-1:0]  timer_reg,  timer_next;
    logic [pcsw_pkg::DATA_W-1:0]  pulses_reg, pulses_next;
    logic [pcsw_pkg::DATA_W-1:0]  latch_reg,  latch_next;
    logic                         wire_reg,   wire_next;
    logic                         rejected;
    logic                         done;
    logic [pcsw_pkg::HOLD_W-1:0]  pulse_load;

    assign pulse_load = {{(pcsw_pkg::HOLD_W-pcsw_pkg::PULSE_W){1'b0}}, cfg.pulse_ticks};

    always_comb
    begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        pulses_next = pulses_reg;
        latch_next  = latch_reg;
        wire_next   = wire_reg;
        rejected    = 1'b0;
        done        = 1'b0;
        case (item.action)
            pcsw_pkg::ACT_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (timer_reg > 16'd1)
                    begin
                        timer_next = timer_reg - 16'd1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_A_LOW, PH_D_LOW:
                            begin
                                wire_next = 1'b1;
                                if (pulses_reg != '0)
                                begin
                                    pulses_next = pulses_reg - 8'd1;
                                    phase_next  = (phase_reg == PH_A_LOW) ? PH_A_HIGH
                                                                          : PH_D_HIGH;
                                    timer_next  = pulse_load;
                                end
                                else
                                begin
                                    phase_next = (phase_reg == PH_A_LOW) ? PH_A_HOLD
                                                                         : PH_D_HOLD;
                                    timer_next = cfg.hold_ticks;
                                end
                            end
                            PH_A_HIGH:
                            begin
                                wire_next  = 1'b0;
                                phase_next = PH_A_LOW;
                                timer_next = pulse_load;
                            end
                            PH_A_HOLD:
                            begin
                                wire_next   = 1'b0;
                                phase_next  = PH_D_LOW;
                                timer_next  = pulse_load;
                                pulses_next = latch_reg;
                            end
                            PH_D_HIGH:
                            begin
                                wire_next  = 1'b0;
                                phase_next = PH_D_LOW;
                                timer_next = pulse_load;
                            end
                            default:
                            begin
                                // final hold over
                                wire_next  = 1'b1;
                                phase_next = PH_IDLE;
                                timer_next = '0;
                                done       = 1'b1;
                            end
                        endcase
                    end
                end
            end
            pcsw_pkg::ACT_SEND:
            begin
                if (phase_reg != PH_IDLE || item.address > pcsw_pkg::MAX_ADDRESS)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    wire_next   = 1'b0;
                    phase_next  = PH_A_LOW;
                    timer_next  = pulse_load;
                    pulses_next = {{(pcsw_pkg::DATA_W-pcsw_pkg::ADDRESS_W){1'b0}},
                                   item.address};
                    latch_next  = item.data;
                end
            end
            pcsw_pkg::ACT_OFF:
            begin
                if (phase_reg != PH_IDLE)
                    rejected = 1'b1;
                else
                    wire_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            timer_reg  <= '0;
            pulses_reg <= '0;
            latch_reg  <= '0;
            wire_reg   <= 1'b1;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            pulses_reg <= pulses_next;
            latch_reg  <= latch_next;
            wire_reg   <= wire_next;
        end
    end

    assign result.line_level = wire_next;
    assign result.busy_res   = (phase_next != PH_IDLE);
    assign result.rejected   = rejected;
    assign result.frame_done = done;

endmodule

/* hdl/pulse_count_single_wire_writer_core.sv */
// pulse-count single-wire writer: top level with input and result registers
// a result is registered: each transaction passes the input register, then the result register
// throughput: one transaction per cycle while the result channel is ready; a stalled out_ch.ready holds the flow
// an input transaction is taken while a finished result waits only if the input register is
// empty, as a full input register frees only when the result register can load
// reset (rst_n low, async): line high, sequencer idle, pulse_ticks 1, hold_ticks 560
module pulse_count_single_wire_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    pcsw_in_if.sink     in_ch,
    pcsw_out_if.source  out_ch,
    pcsw_cfg_if.sink    cfg_ch
);

    // input register stage
    logic               in_valid_reg, in_valid_next;
    pcsw_pkg::item_t    in_item_reg;
    logic               in_take;

    // result register stage
    logic               out_valid_reg, out_valid_next;
    pcsw_pkg::result_t  out_res_reg;
    logic               out_load;

    // sequencer step and its result
    logic               step;
    pcsw_pkg::result_t  step_res;
    pcsw_pkg::cfg_t     cfg;

    // result register may load when empty or when its transaction leaves this cycle
    assign out_load = !out_valid_reg || out_ch.ready;

    // the held item moves through the sequencer into the result register
    assign step = in_valid_reg && out_load;

    // input register frees when its item steps
    assign in_ch.ready = !in_valid_reg || out_load;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.action  <= in_ch.action;
            in_item_reg.address <= in_ch.address;
            in_item_reg.data    <= in_ch.data;
        end
        if (step)
            out_res_reg <= step_res;
    end

    pcsw_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    // phase, timer and pulse counters advance once per stepped transaction
    pcsw_frame_fsm u_frame_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_res)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.line_level = out_res_reg.line_level;
    assign out_ch.busy_res   = out_res_reg.busy_res;
    assign out_ch.rejected   = out_res_reg.rejected;
    assign out_ch.frame_done = out_res_reg.frame_done;

endmodule
